// File: rtl/ssr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session supervisor package
// Shared codes, configuration defaults, the transition legality table and the
// structures passed between the supervisor modules.
// ----------------------------------------------------------------------------
package ssr_pkg;

  localparam int ATTEMPT_LIMIT = 16;
  localparam int DELAY_BITS    = 16;
  localparam int SEQUENCE_BITS = 32;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_START_ENABLED = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ATTEMPTS  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_FIRST   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_SECOND  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_THIRD   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_LATER   = 3'd5;

  localparam logic        START_ENABLED_RST = 1'b1;
  localparam logic [4:0]  MAX_ATTEMPTS_RST  = 5'd5;
  localparam logic [15:0] DELAY_FIRST_RST   = 16'd1000;
  localparam logic [15:0] DELAY_SECOND_RST  = 16'd2000;
  localparam logic [15:0] DELAY_THIRD_RST   = 16'd5000;
  localparam logic [15:0] DELAY_LATER_RST   = 16'd10000;

  localparam logic [2:0] ST_DISABLED     = 3'd0;
  localparam logic [2:0] ST_DISCONNECTED = 3'd1;
  localparam logic [2:0] ST_CONNECTING   = 3'd2;
  localparam logic [2:0] ST_CONNECTED    = 3'd3;
  localparam logic [2:0] ST_STARTING     = 3'd4;
  localparam logic [2:0] ST_STREAMING    = 3'd5;
  localparam logic [2:0] ST_RECOVERING   = 3'd6;
  localparam logic [2:0] ST_FAULTED      = 3'd7;

  localparam logic [2:0] KIND_MOVE        = 3'd0;
  localparam logic [2:0] KIND_FAILURE     = 3'd1;
  localparam logic [2:0] KIND_STOP        = 3'd2;
  localparam logic [2:0] KIND_FAULT_RESET = 3'd3;
  localparam logic [2:0] KIND_TICK        = 3'd4;

  localparam logic [1:0] STATUS_REJECTED = 2'd0;
  localparam logic [1:0] STATUS_ACCEPTED = 2'd1;
  localparam logic [1:0] STATUS_ALREADY  = 2'd2;

  // Bit t of entry f is set when a move from state f to state t is allowed.
  localparam logic [7:0] LEGAL_MOVES [8] = '{
    8'h02, 8'h05, 8'hCB, 8'hD3, 8'hE3, 8'hC3, 8'h87, 8'h03
  };

  typedef struct packed {
    logic [4:0]  max_attempts;
    logic [15:0] delay_first;
    logic [15:0] delay_second;
    logic [15:0] delay_third;
    logic [15:0] delay_later;
  } cfg_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] target_state;
    logic       retryable;
    logic [7:0] error_code;
    logic       has_cause;
    logic       stay_enabled;
  } event_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  from_state;
    logic [2:0]  to_state;
    logic [31:0] sequence_res;
    logic [4:0]  attempts_used;
    logic        retry_pending;
    logic        stop_flag;
    logic        error_valid;
    logic [7:0]  error_held;
    logic        retries_exhausted;
  } result_t;

  function automatic logic is_legal(input logic [2:0] from, input logic [2:0] to);
    logic [7:0] row;
    row = LEGAL_MOVES[from];
    return row[to];
  endfunction

endpackage

// File: rtl/ssr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session supervisor channels
// Valid/ready channels for supervisor events and for supervisor results.
// ----------------------------------------------------------------------------
interface ssr_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [2:0] target_state;
  logic       retryable;
  logic [7:0] error_code;
  logic       has_cause;
  logic       stay_enabled;

  modport source (
    output valid, kind, target_state, retryable, error_code, has_cause, stay_enabled,
    input  ready
  );
  modport sink (
    input  valid, kind, target_state, retryable, error_code, has_cause, stay_enabled,
    output ready
  );
endinterface

interface ssr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [2:0]  from_state;
  logic [2:0]  to_state;
  logic [31:0] sequence_res;
  logic [4:0]  attempts_used;
  logic        retry_pending;
  logic        stop_flag;
  logic        error_valid;
  logic [7:0]  error_held;
  logic        retries_exhausted;

  modport source (
    output valid, status, from_state, to_state, sequence_res, attempts_used,
           retry_pending, stop_flag, error_valid, error_held, retries_exhausted,
    input  ready
  );
  modport sink (
    input  valid, status, from_state, to_state, sequence_res, attempts_used,
           retry_pending, stop_flag, error_valid, error_held, retries_exhausted,
    output ready
  );
endinterface

// File: rtl/session_supervisor_with_retry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session supervisor with retry
// Path: an accepted event waits in ev_reg; its result beat is held in res_reg.
// Throughput: one event per cycle unless the result channel stalls.
// Events that produce no result (idle ticks, unknown kinds) still step the core.
// Reset: synchronous; the session starts disconnected with all counters clear.
// ----------------------------------------------------------------------------
module session_supervisor_with_retry #(
  parameter int DELAY_BITS    = ssr_pkg::DELAY_BITS,
  parameter int SEQUENCE_BITS = ssr_pkg::SEQUENCE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ssr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ssr_pkg::CFG_DATA_W-1:0]  cfg_data,
  ssr_in_if.sink                          in_ch,
  ssr_out_if.source                       out_ch
);

  ssr_pkg::cfg_t    cfg;
  ssr_pkg::event_t  ev_reg;
  ssr_pkg::result_t res;
  ssr_pkg::result_t res_reg;
  logic             ev_valid;
  logic             out_valid;
  logic             advance;
  logic             step;
  logic             emit;

  ssr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ssr_core #(
    .DELAY_BITS    (DELAY_BITS),
    .SEQUENCE_BITS (SEQUENCE_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (step),
    .ev   (ev_reg),
    .emit (emit),
    .res  (res)
  );

  assign advance     = !out_valid || out_ch.ready;
  assign step        = ev_valid && advance;
  assign in_ch.ready = !ev_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (in_ch.ready) begin
      ev_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      ev_reg.kind         <= in_ch.kind;
      ev_reg.target_state <= in_ch.target_state;
      ev_reg.retryable    <= in_ch.retryable;
      ev_reg.error_code   <= in_ch.error_code;
      ev_reg.has_cause    <= in_ch.has_cause;
      ev_reg.stay_enabled <= in_ch.stay_enabled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      res_reg <= res;
    end
  end

  assign out_ch.valid             = out_valid;
  assign out_ch.status            = res_reg.status;
  assign out_ch.from_state        = res_reg.from_state;
  assign out_ch.to_state          = res_reg.to_state;
  assign out_ch.sequence_res      = res_reg.sequence_res;
  assign out_ch.attempts_used     = res_reg.attempts_used;
  assign out_ch.retry_pending     = res_reg.retry_pending;
  assign out_ch.stop_flag         = res_reg.stop_flag;
  assign out_ch.error_valid       = res_reg.error_valid;
  assign out_ch.error_held        = res_reg.error_held;
  assign out_ch.retries_exhausted = res_reg.retries_exhausted;

endmodule

// File: rtl/ssr_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session supervisor configuration registers
// Holds the attempt limit and the backoff delays written over the config port.
// ----------------------------------------------------------------------------
module ssr_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ssr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ssr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output ssr_pkg::cfg_t                  cfg
);

  // The start_enabled register only selects the reset state, which is fixed
  // by its reset value, so a write to it changes nothing here.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_attempts <= ssr_pkg::MAX_ATTEMPTS_RST;
      cfg.delay_first  <= ssr_pkg::DELAY_FIRST_RST;
      cfg.delay_second <= ssr_pkg::DELAY_SECOND_RST;
      cfg.delay_third  <= ssr_pkg::DELAY_THIRD_RST;
      cfg.delay_later  <= ssr_pkg::DELAY_LATER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ssr_pkg::CFG_MAX_ATTEMPTS: cfg.max_attempts <= cfg_data[4:0];
        ssr_pkg::CFG_DELAY_FIRST:  cfg.delay_first  <= cfg_data;
        ssr_pkg::CFG_DELAY_SECOND: cfg.delay_second <= cfg_data;
        ssr_pkg::CFG_DELAY_THIRD:  cfg.delay_third  <= cfg_data;
        ssr_pkg::CFG_DELAY_LATER:  cfg.delay_later  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/ssr_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session supervisor core
// Session state registers and the combinational update for one event, giving
// the result beat that the event produces.
// ----------------------------------------------------------------------------
module ssr_core #(
  parameter int DELAY_BITS    = ssr_pkg::DELAY_BITS,
  parameter int SEQUENCE_BITS = ssr_pkg::SEQUENCE_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  ssr_pkg::cfg_t    cfg,
  input  logic             step,
  input  ssr_pkg::event_t  ev,
  output logic             emit,
  output ssr_pkg::result_t res
);

  logic [2:0]               state, state_next;
  logic [4:0]               attempts, attempts_next;
  logic                     pending, pending_next;
  logic [DELAY_BITS-1:0]    remaining, remaining_next;
  logic                     stop_req, stop_req_next;
  logic                     err_valid, err_valid_next;
  logic [7:0]               err_code, err_code_next;
  logic [SEQUENCE_BITS-1:0] seq, seq_next;

  logic        mv_do;
  logic [2:0]  mv_tgt;
  logic        mv_err;
  logic [1:0]  status;
  logic        exhausted;
  logic [4:0]  att_limit;
  logic [15:0] delay_sel;
  logic        tick_done;

  assign att_limit = (32'(attempts) < 32'(ssr_pkg::ATTEMPT_LIMIT) ||
                      32'(cfg.max_attempts) < 32'(ssr_pkg::ATTEMPT_LIMIT))
                     ? ((32'(cfg.max_attempts) < 32'(ssr_pkg::ATTEMPT_LIMIT))
                        ? cfg.max_attempts : 5'(ssr_pkg::ATTEMPT_LIMIT))
                     : 5'(ssr_pkg::ATTEMPT_LIMIT);

  always_comb begin
    case (attempts)
      5'd0:    delay_sel = cfg.delay_first;
      5'd1:    delay_sel = cfg.delay_second;
      5'd2:    delay_sel = cfg.delay_third;
      default: delay_sel = cfg.delay_later;
    endcase
  end

  assign tick_done = (remaining == '0) || (remaining == DELAY_BITS'(1));

  always_comb begin
    state_next     = state;
    attempts_next  = attempts;
    pending_next   = pending;
    remaining_next = remaining;
    stop_req_next  = stop_req;
    err_valid_next = err_valid;
    err_code_next  = err_code;
    seq_next       = seq;
    mv_do          = 1'b0;
    mv_tgt         = ev.target_state;
    mv_err         = 1'b0;
    status         = ssr_pkg::STATUS_REJECTED;
    exhausted      = 1'b0;
    emit           = 1'b0;

    case (ev.kind)
      ssr_pkg::KIND_MOVE: begin
        emit   = 1'b1;
        mv_do  = 1'b1;
        mv_err = ev.has_cause;
      end
      ssr_pkg::KIND_FAILURE: begin
        emit   = 1'b1;
        mv_do  = 1'b1;
        mv_err = 1'b1;
        mv_tgt = ssr_pkg::ST_FAULTED;
        if (ev.retryable && !stop_req) begin
          if (!ssr_pkg::is_legal(state, ssr_pkg::ST_RECOVERING) || pending) begin
            mv_tgt = ssr_pkg::ST_RECOVERING;
          end else if (attempts < att_limit) begin
            attempts_next  = attempts + 5'd1;
            pending_next   = 1'b1;
            remaining_next = DELAY_BITS'(delay_sel);
            mv_tgt         = ssr_pkg::ST_RECOVERING;
          end else begin
            exhausted = 1'b1;
          end
        end
      end
      ssr_pkg::KIND_STOP: begin
        emit           = 1'b1;
        stop_req_next  = 1'b1;
        pending_next   = 1'b0;
        remaining_next = '0;
        mv_tgt = ev.stay_enabled ? ssr_pkg::ST_DISCONNECTED : ssr_pkg::ST_DISABLED;
        if (state == mv_tgt) begin
          status = ssr_pkg::STATUS_ALREADY;
        end else begin
          mv_do = 1'b1;
        end
      end
      ssr_pkg::KIND_FAULT_RESET: begin
        emit  = 1'b1;
        mv_do = 1'b1;
        if (state != ssr_pkg::ST_FAULTED) begin
          mv_tgt = state;
        end else begin
          stop_req_next = 1'b0;
          mv_tgt        = ssr_pkg::ST_DISCONNECTED;
        end
      end
      ssr_pkg::KIND_TICK: begin
        if (pending) begin
          if (remaining != '0) begin
            remaining_next = remaining - DELAY_BITS'(1);
          end
          if (tick_done) begin
            pending_next = 1'b0;
            if (!stop_req && state == ssr_pkg::ST_RECOVERING) begin
              emit   = 1'b1;
              mv_do  = 1'b1;
              mv_tgt = ssr_pkg::ST_CONNECTING;
            end
          end
        end
      end
      default: ;
    endcase

    if (mv_do) begin
      seq_next = seq + SEQUENCE_BITS'(1);
      if (ssr_pkg::is_legal(state, mv_tgt)) begin
        status     = ssr_pkg::STATUS_ACCEPTED;
        state_next = mv_tgt;
        if (mv_err) begin
          err_valid_next = 1'b1;
          err_code_next  = ev.error_code;
        end
        if (mv_tgt == ssr_pkg::ST_STREAMING) begin
          attempts_next  = '0;
          pending_next   = 1'b0;
          remaining_next = '0;
          stop_req_next  = 1'b0;
          err_valid_next = 1'b0;
          err_code_next  = '0;
        end else if (mv_tgt == ssr_pkg::ST_DISCONNECTED &&
                     (state == ssr_pkg::ST_FAULTED || state == ssr_pkg::ST_DISABLED)) begin
          attempts_next  = '0;
          pending_next   = 1'b0;
          remaining_next = '0;
          err_valid_next = 1'b0;
          err_code_next  = '0;
          if (state == ssr_pkg::ST_DISABLED) begin
            stop_req_next = 1'b0;
          end
        end else if (mv_tgt == ssr_pkg::ST_DISABLED ||
                     mv_tgt == ssr_pkg::ST_DISCONNECTED) begin
          pending_next   = 1'b0;
          remaining_next = '0;
        end else if (mv_tgt == ssr_pkg::ST_CONNECTING) begin
          stop_req_next = 1'b0;
        end
      end
    end
  end

  always_comb begin
    res.status            = status;
    res.from_state        = state;
    res.to_state          = mv_tgt;
    res.sequence_res      = 32'(seq_next);
    res.attempts_used     = attempts_next;
    res.retry_pending     = pending_next;
    res.stop_flag         = stop_req_next;
    res.error_valid       = err_valid_next;
    res.error_held        = err_valid_next ? err_code_next : 8'd0;
    res.retries_exhausted = exhausted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ssr_pkg::START_ENABLED_RST ? ssr_pkg::ST_DISCONNECTED
                                              : ssr_pkg::ST_DISABLED;
      attempts  <= '0;
      pending   <= 1'b0;
      remaining <= '0;
      stop_req  <= 1'b0;
      err_valid <= 1'b0;
      err_code  <= '0;
      seq       <= '0;
    end else if (step) begin
      state     <= state_next;
      attempts  <= attempts_next;
      pending   <= pending_next;
      remaining <= remaining_next;
      stop_req  <= stop_req_next;
      err_valid <= err_valid_next;
      err_code  <= err_code_next;
      seq       <= seq_next;
    end
  end

endmodule
